[design/snyr_pkg.sv]
// package: shared types and constants of the sample normalizer and ycc to rgb converter
package snyr_pkg;

  localparam int SampleW = 17;
  localparam int ChanW   = 8;
  localparam int PrecW   = 5;
  localparam int ModeW   = 2;
  localparam int IdxW    = 3;
  localparam int DataW   = 5;

  // color mode codes, code three behaves as rgb
  typedef enum logic [ModeW-1:0] {
    MODE_GREY = 2'd0,
    MODE_RGB  = 2'd1,
    MODE_SYCC = 2'd2
  } mode_t;

  // register indexes of the write port
  localparam logic [IdxW-1:0] RegColorMode = 3'd0;
  localparam logic [IdxW-1:0] RegPrecZero  = 3'd1;
  localparam logic [IdxW-1:0] RegPrecOne   = 3'd2;
  localparam logic [IdxW-1:0] RegPrecTwo   = 3'd3;
  localparam logic [IdxW-1:0] RegSgnZero   = 3'd4;
  localparam logic [IdxW-1:0] RegSgnOne    = 3'd5;
  localparam logic [IdxW-1:0] RegSgnTwo    = 3'd6;

  // bt.601 coefficients, 16 fractional bits
  localparam logic signed [17:0] CoefCrR = 18'sd91881;
  localparam logic signed [17:0] CoefCbG = 18'sd22554;
  localparam logic signed [17:0] CoefCrG = 18'sd46802;
  localparam logic signed [17:0] CoefCbB = 18'sd116130;
  localparam logic [ChanW:0]     ChromaMid = 9'd128;
  localparam logic [ChanW-1:0]   ChanMax   = 8'd255;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [PrecW-1:0] prec_zero;
    logic [PrecW-1:0] prec_one;
    logic [PrecW-1:0] prec_two;
    logic             sgn_zero;
    logic             sgn_one;
    logic             sgn_two;
  } cfg_t;

  // load enables of a two-register section of the pipeline
  typedef struct packed {
    logic first;
    logic second;
  } stage_en_t;

endpackage

[design/snyr_if.sv]
// interfaces: input pixel channel and output pixel channel
interface snyr_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [snyr_pkg::SampleW-1:0] sample_zero;
  logic signed [snyr_pkg::SampleW-1:0] sample_one;
  logic signed [snyr_pkg::SampleW-1:0] sample_two;

  modport source (output valid, sample_zero, sample_one, sample_two, input ready);
  modport sink   (input valid, sample_zero, sample_one, sample_two, output ready);
endinterface

interface snyr_out_if;
  logic                          valid;
  logic                          ready;
  logic [snyr_pkg::ChanW-1:0]    red;
  logic [snyr_pkg::ChanW-1:0]    green;
  logic [snyr_pkg::ChanW-1:0]    blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

[design/sample_normalize_ycc_to_rgb_top.sv]
// top level: sample normalizer and bt.601 ycc to rgb converter
//
//   channel   role    handshake      payload
//   pix_in    sink    valid/ready    sample_zero, sample_one, sample_two (17 bit signed)
//   pix_out   source  valid/ready    red, green, blue (8 bit unsigned)
//   wr_*      sink    wr_en only     wr_index (3 bit), wr_data (5 bit)
//
// four register stages: offset, shift and clamp, coefficient products,
// sum and saturate into the output register
// one pixel transaction per clock while pix_out does not stall; an accepted pixel moves
// through the stages in order, and pix_out.valid is the valid bit of the output register
// rst is synchronous and clears the valid bits and the configuration registers to their defaults
// each stage loads when it is empty or the stage after it moves, so a stall on pix_out
// fills the bubbles ahead of it before pix_in.ready drops; nothing is lost or repeated
module sample_normalize_ycc_to_rgb_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [snyr_pkg::IdxW-1:0]   wr_index,
  input  logic [snyr_pkg::DataW-1:0]  wr_data,
  snyr_in_if.sink                     pix_in,
  snyr_out_if.source                  pix_out
);
  import snyr_pkg::*;

  cfg_t cfg;

  // valid bits of stages one to four, stage four is the output register
  logic vld1, vld2, vld3, vld4;
  logic en1, en2, en3, en4;
  stage_en_t norm_en;
  stage_en_t csc_en;

  logic [ChanW-1:0] c0, c1, c2;

  // load enables ripple back from the output side
  assign en4 = !vld4 || pix_out.ready;
  assign en3 = !vld3 || en4;
  assign en2 = !vld2 || en3;
  assign en1 = !vld1 || en2;

  assign pix_in.ready  = en1;
  assign pix_out.valid = vld4;

  assign norm_en.first  = en1;
  assign norm_en.second = en2;
  assign csc_en.first   = en3;
  assign csc_en.second  = en4;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
      vld4 <= 1'b0;
    end else begin
      if (en1) vld1 <= pix_in.valid;
      if (en2) vld2 <= vld1;
      if (en3) vld3 <= vld2;
      if (en4) vld4 <= vld3;
    end
  end

  snyr_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  // the three components are normalized side by side
  snyr_norm u_norm_zero (
    .clk    (clk),
    .en     (norm_en),
    .sample (pix_in.sample_zero),
    .prec   (cfg.prec_zero),
    .sgnd   (cfg.sgn_zero),
    .comp   (c0)
  );

  snyr_norm u_norm_one (
    .clk    (clk),
    .en     (norm_en),
    .sample (pix_in.sample_one),
    .prec   (cfg.prec_one),
    .sgnd   (cfg.sgn_one),
    .comp   (c1)
  );

  snyr_norm u_norm_two (
    .clk    (clk),
    .en     (norm_en),
    .sample (pix_in.sample_two),
    .prec   (cfg.prec_two),
    .sgnd   (cfg.sgn_two),
    .comp   (c2)
  );

  // mode is read live; the user must change it only while the pipeline is empty, the block does not enforce this
  snyr_csc u_csc (
    .clk   (clk),
    .en    (csc_en),
    .mode  (cfg.mode),
    .c0    (c0),
    .c1    (c1),
    .c2    (c2),
    .red   (pix_out.red),
    .green (pix_out.green),
    .blue  (pix_out.blue)
  );
endmodule

[design/snyr_cfg.sv]
// configuration register file
module snyr_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [snyr_pkg::IdxW-1:0]   wr_index,
  input  logic [snyr_pkg::DataW-1:0]  wr_data,
  output snyr_pkg::cfg_t              cfg
);
  import snyr_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode      <= MODE_GREY;
      cfg.prec_zero <= 5'd8;
      cfg.prec_one  <= 5'd8;
      cfg.prec_two  <= 5'd8;
      cfg.sgn_zero  <= 1'b0;
      cfg.sgn_one   <= 1'b0;
      cfg.sgn_two   <= 1'b0;
    end else if (wr_en) begin
      unique case (wr_index)
        RegColorMode: cfg.mode      <= wr_data[ModeW-1:0];
        RegPrecZero:  cfg.prec_zero <= wr_data[PrecW-1:0];
        RegPrecOne:   cfg.prec_one  <= wr_data[PrecW-1:0];
        RegPrecTwo:   cfg.prec_two  <= wr_data[PrecW-1:0];
        RegSgnZero:   cfg.sgn_zero  <= wr_data[0];
        RegSgnOne:    cfg.sgn_one   <= wr_data[0];
        RegSgnTwo:    cfg.sgn_two   <= wr_data[0];
        default: ;
      endcase
    end
  end
endmodule

[design/snyr_norm.sv]
// one component normalizer: offset stage, then shift and clamp stage
module snyr_norm (
  input  logic                                clk,
  input  snyr_pkg::stage_en_t                 en,
  input  logic signed [snyr_pkg::SampleW-1:0] sample,
  input  logic [snyr_pkg::PrecW-1:0]          prec,
  input  logic                                sgnd,
  output logic [snyr_pkg::ChanW-1:0]          comp
);
  import snyr_pkg::*;

  logic [PrecW-1:0] p_eff;
  logic [31:0]      offset;
  logic [32:0]      sum;

  logic [30:0]      mag;
  logic             neg;
  logic [PrecW-1:0] p_q;
  logic [37:0]      wide;

  // precision zero acts as one
  assign p_eff  = (prec == '0) ? 5'd1 : prec;
  assign offset = sgnd ? (32'd1 << (p_eff - 5'd1)) : 32'd0;
  assign sum    = {{16{sample[SampleW-1]}}, sample} + {1'b0, offset};

  always_ff @(posedge clk) begin
    if (en.first) begin
      mag <= sum[30:0];
      neg <= sum[32];
      p_q <= p_eff;
    end
  end

  always_comb begin
    if (p_q >= 5'd8) begin
      wide = {7'd0, mag >> (p_q - 5'd8)};
    end else begin
      wide = {7'd0, mag} << (5'd8 - p_q);
    end
  end

  always_ff @(posedge clk) begin
    if (en.second) begin
      if (neg) begin
        comp <= '0;
      end else if (wide > 38'd255) begin
        comp <= ChanMax;
      end else begin
        comp <= wide[ChanW-1:0];
      end
    end
  end
endmodule

[design/snyr_csc.sv]
// color conversion: product stage, then sum, saturate and mode select into the output register
module snyr_csc (
  input  logic                       clk,
  input  snyr_pkg::stage_en_t        en,
  input  logic [snyr_pkg::ModeW-1:0] mode,
  input  logic [snyr_pkg::ChanW-1:0] c0,
  input  logic [snyr_pkg::ChanW-1:0] c1,
  input  logic [snyr_pkg::ChanW-1:0] c2,
  output logic [snyr_pkg::ChanW-1:0] red,
  output logic [snyr_pkg::ChanW-1:0] green,
  output logic [snyr_pkg::ChanW-1:0] blue
);
  import snyr_pkg::*;

  function automatic logic [ChanW-1:0] sat8(input logic signed [12:0] v);
    if (v < 13'sd0) begin
      return '0;
    end else if (v > 13'sd255) begin
      return ChanMax;
    end
    return v[ChanW-1:0];
  endfunction

  logic signed [ChanW:0] cb;
  logic signed [ChanW:0] cr;
  logic signed [26:0]    p_r, p_gb, p_gr, p_b;
  logic [ChanW-1:0]      c0_q, c1_q, c2_q;
  logic signed [27:0]    g_sum;
  logic signed [12:0]    y_ext;
  logic signed [12:0]    r_s, g_s, b_s;

  assign cb = $signed({1'b0, c1} - ChromaMid);
  assign cr = $signed({1'b0, c2} - ChromaMid);

  always_ff @(posedge clk) begin
    if (en.first) begin
      p_r  <= 27'(CoefCrR) * 27'(cr);
      p_gb <= 27'(CoefCbG) * 27'(cb);
      p_gr <= 27'(CoefCrG) * 27'(cr);
      p_b  <= 27'(CoefCbB) * 27'(cb);
      c0_q <= c0;
      c1_q <= c1;
      c2_q <= c2;
    end
  end

  // dropping the low 16 bits of a signed product is a floor shift
  assign g_sum = 28'(p_gb) + 28'(p_gr);
  assign y_ext = $signed({5'd0, c0_q});
  assign r_s   = y_ext + 13'($signed(p_r[26:16]));
  assign g_s   = y_ext - 13'($signed(g_sum[27:16]));
  assign b_s   = y_ext + 13'($signed(p_b[26:16]));

  always_ff @(posedge clk) begin
    if (en.second) begin
      case (mode)
        MODE_GREY: begin
          red   <= c0_q;
          green <= c0_q;
          blue  <= c0_q;
        end
        MODE_SYCC: begin
          red   <= sat8(r_s);
          green <= sat8(g_s);
          blue  <= sat8(b_s);
        end
        default: begin
          red   <= c0_q;
          green <= c1_q;
          blue  <= c2_q;
        end
      endcase
    end
  end
endmodule
